/* hdl/bsfm_pkg.sv */
// ----------------------------------------------------------------------------
// bsfm_pkg
// Shared types and functions for the binomial smoothing filter.
// ----------------------------------------------------------------------------
package bsfm_pkg;

  localparam int MAX_ORDER = 30;

  typedef struct packed {
    logic line_done;
    logic short_line;
  } bsfm_flags_t;

  // Binomial coefficient C(n, k) by Pascal's rule, for elaboration-time use.
  function automatic longint binom(input int n, input int k);
    longint row [0:MAX_ORDER];
    for (int i = 0; i <= MAX_ORDER; i++) begin
      row[i] = 0;
    end
    row[0] = 1;
    for (int i = 1; i <= n; i++) begin
      for (int j = i; j > 0; j--) begin
        row[j] = row[j] + row[j - 1];
      end
    end
    return row[k];
  endfunction

endpackage

/* hdl/binomial_smoothing_fir_mirror.sv */
// ----------------------------------------------------------------------------
// binomial_smoothing_fir_mirror
// Binomial line smoother with half-sample mirrored ends.
// ----------------------------------------------------------------------------
// Takes one signed sample per cycle while the chain takes it. An ordinary
// sample is accepted every cycle unless the output stalls; the sample that
// ends a line (when the line is at least HALF_WIDTH+1 long) holds the
// input while the remaining outputs are issued from the stored window.
// Each output passes a tap-select register and a chain of 2*HALF_WIDTH+1
// multiply-accumulate cells, one per tap. A line shorter than
// HALF_WIDTH+1 samples yields a single result with short_line set.
// The chain drains into bubbles on its own, so input keeps flowing while a
// result waits, until every stage is full.
// ----------------------------------------------------------------------------
module binomial_smoothing_fir_mirror
  import bsfm_pkg::*;
#(
  parameter int HALF_WIDTH  = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          end_of_line,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [SAMPLE_BITS-1:0] smoothed,
  output logic                          line_done,
  output logic                          short_line
);

  localparam int TAPS  = 2 * HALF_WIDTH + 1;
  localparam int ACC_W = SAMPLE_BITS + 2 * HALF_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(longint'(1) << (2 * HALF_WIDTH - 1));

  logic                         valid_chain [TAPS+1];
  logic                         ready_chain [TAPS+1];
  logic signed [ACC_W-1:0]      sum_chain   [TAPS+1];
  logic [TAPS*SAMPLE_BITS-1:0]  taps_chain  [TAPS+1];
  bsfm_flags_t                  flags_chain [TAPS+1];

  bsfm_front #(
    .HALF_WIDTH  (HALF_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .end_of_line  (end_of_line),
    .tap_valid    (valid_chain[0]),
    .tap_ready    (ready_chain[0]),
    .taps         (taps_chain[0]),
    .tap_flags    (flags_chain[0])
  );

  assign sum_chain[0] = ROUND;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    bsfm_mac_cell #(
      .HALF_WIDTH  (HALF_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_chain[i]),
      .in_ready  (ready_chain[i]),
      .in_sum    (sum_chain[i]),
      .in_taps   (taps_chain[i]),
      .in_flags  (flags_chain[i]),
      .out_valid (valid_chain[i+1]),
      .out_ready (ready_chain[i+1]),
      .out_sum   (sum_chain[i+1]),
      .out_taps  (taps_chain[i+1]),
      .out_flags (flags_chain[i+1])
    );
  end

  assign ready_chain[TAPS] = result_ready;
  assign result_valid      = valid_chain[TAPS];
  assign smoothed          = sum_chain[TAPS][2*HALF_WIDTH +: SAMPLE_BITS];
  assign line_done         = flags_chain[TAPS].line_done;
  assign short_line        = flags_chain[TAPS].short_line;

endmodule

/* hdl/bsfm_mac_cell.sv */
// ----------------------------------------------------------------------------
// bsfm_mac_cell
// One tap of the accumulate chain: adds its weighted tap to the running sum
// and hands sum, taps and flags to the next cell.
// ----------------------------------------------------------------------------
module bsfm_mac_cell
  import bsfm_pkg::*;
#(
  parameter int HALF_WIDTH  = 3,
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX       = 0
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic signed [SAMPLE_BITS+2*HALF_WIDTH:0]    in_sum,
  input  logic [(2*HALF_WIDTH+1)*SAMPLE_BITS-1:0]     in_taps,
  input  bsfm_flags_t                                 in_flags,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic signed [SAMPLE_BITS+2*HALF_WIDTH:0]    out_sum,
  output logic [(2*HALF_WIDTH+1)*SAMPLE_BITS-1:0]     out_taps,
  output bsfm_flags_t                                 out_flags
);

  localparam int ACC_W = SAMPLE_BITS + 2 * HALF_WIDTH + 1;
  localparam logic signed [ACC_W-1:0] WEIGHT = ACC_W'(binom(2 * HALF_WIDTH, INDEX));

  logic                    load;
  logic [SAMPLE_BITS-1:0]  tap;
  logic signed [ACC_W-1:0] tap_ext;
  logic signed [ACC_W-1:0] product;

  assign load     = !out_valid || out_ready;
  assign in_ready = load;
  assign tap      = in_taps[INDEX*SAMPLE_BITS +: SAMPLE_BITS];
  assign tap_ext  = $signed({{(ACC_W - SAMPLE_BITS){tap[SAMPLE_BITS-1]}}, tap});
  assign product  = tap_ext * WEIGHT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_sum   <= in_sum + product;
      out_taps  <= in_taps;
      out_flags <= in_flags;
    end
  end

endmodule

/* hdl/bsfm_front.sv */
// ----------------------------------------------------------------------------
// bsfm_front
// Sample window, line counting, end-of-line flush sequencing and the
// mirrored tap selection, registered into the tap word for the chain.
// ----------------------------------------------------------------------------
module bsfm_front
  import bsfm_pkg::*;
#(
  parameter int HALF_WIDTH  = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     sample_valid,
  output logic                                     sample_ready,
  input  logic signed [SAMPLE_BITS-1:0]            sample,
  input  logic                                     end_of_line,
  output logic                                     tap_valid,
  input  logic                                     tap_ready,
  output logic [(2*HALF_WIDTH+1)*SAMPLE_BITS-1:0]  taps,
  output bsfm_flags_t                              tap_flags
);

  localparam int TAPS  = 2 * HALF_WIDTH + 1;
  localparam int CNT_W = $clog2(TAPS + 1);
  localparam int FW    = $clog2(HALF_WIDTH + 1);
  localparam int IDX_W = $clog2(TAPS);
  localparam int AW    = $clog2(2 * TAPS + 1) + 1;

  logic [SAMPLE_BITS-1:0] window [TAPS];
  logic [SAMPLE_BITS-1:0] win_next [TAPS];
  logic [SAMPLE_BITS-1:0] sel_win [TAPS];
  logic [CNT_W-1:0]       line_count;
  logic [CNT_W-1:0]       n_new;
  logic [CNT_W-1:0]       flush_n;
  logic [FW-1:0]          flush_f;
  logic                   flushing;

  logic                   load;
  logic                   accept;
  logic                   is_short;
  logic                   emit;
  bsfm_flags_t            flags_d;
  logic [FW-1:0]          sel_f;
  logic [CNT_W-1:0]       sel_n;
  logic signed [AW-1:0]   age [TAPS];
  logic [TAPS*SAMPLE_BITS-1:0] taps_d;

  assign load         = !tap_valid || tap_ready;
  assign sample_ready = load && !flushing;
  assign accept       = sample_valid && sample_ready;
  assign n_new        = (line_count < CNT_W'(TAPS)) ? line_count + 1'b1 : line_count;
  assign is_short     = n_new < CNT_W'(HALF_WIDTH + 1);

  always_comb begin
    win_next[0] = sample;
    for (int i = 1; i < TAPS; i++) begin
      win_next[i] = window[i - 1];
    end
  end

  assign sel_f = flushing ? flush_f : '0;
  assign sel_n = flushing ? flush_n : n_new;

  always_comb begin
    for (int i = 0; i < TAPS; i++) begin
      sel_win[i] = flushing ? window[i] : win_next[i];
    end
  end

  always_comb begin
    emit              = 1'b0;
    flags_d           = '0;
    if (flushing) begin
      emit              = 1'b1;
      flags_d.line_done = (flush_f == FW'(HALF_WIDTH));
    end else if (accept) begin
      if (is_short) begin
        emit               = end_of_line;
        flags_d.line_done  = 1'b1;
        flags_d.short_line = 1'b1;
      end else begin
        emit = 1'b1;
      end
    end
  end

  // Mirrored tap addressing: right end first, then left end, then clamp.
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      age[t] = $signed(AW'(2 * HALF_WIDTH - t)) - $signed(AW'(sel_f));
      if (age[t] < 0) begin
        age[t] = AW'(-age[t] - 1);
      end
      if (age[t] > $signed(AW'(sel_n)) - 1) begin
        age[t] = AW'($signed(AW'(sel_n)) * 2 - 1 - age[t]);
      end
      if (age[t] < 0) begin
        age[t] = '0;
      end
      if (age[t] > $signed(AW'(TAPS - 1))) begin
        age[t] = AW'(TAPS - 1);
      end
      taps_d[t*SAMPLE_BITS +: SAMPLE_BITS] =
        flags_d.short_line ? '0 : sel_win[age[t][IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      flushing   <= 1'b0;
      flush_f    <= '0;
      tap_valid  <= 1'b0;
    end else begin
      if (load) begin
        tap_valid <= emit;
      end
      if (flushing && load) begin
        if (flush_f == FW'(HALF_WIDTH)) begin
          flushing <= 1'b0;
        end else begin
          flush_f <= flush_f + 1'b1;
        end
      end else if (accept) begin
        if (end_of_line) begin
          line_count <= '0;
          if (!is_short) begin
            flushing <= 1'b1;
            flush_f  <= FW'(1);
          end
        end else begin
          line_count <= n_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < TAPS; i++) begin
        window[i] <= win_next[i];
      end
      flush_n <= n_new;
    end
    if (load && emit) begin
      taps      <= taps_d;
      tap_flags <= flags_d;
    end
  end

endmodule

/* verif/binomial_smoothing_fir_mirror_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_smoothing_fir_mirror_tb
// Self-checking bench for the binomial line smoother with mirrored ends.
// A table of directed words covers short lines, the shortest full line and
// full-scale constant lines. Random lines of mixed length follow. Every
// accepted output word is compared with a scoreboard fed by an in-bench
// model of the 7-tap filter. The sender idles in bursts and the receiver
// stalls on changing patterns, with one long hold-off and a mid-run drain.
// ----------------------------------------------------------------------------
module binomial_smoothing_fir_mirror_tb;

  localparam int HALF_W   = 3;
  localparam int SAMPLE_W = 16;
  localparam int TAPS     = 2 * HALF_W + 1;
  localparam int NORM     = 2 * HALF_W;
  localparam int RAND_WORDS = 330;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       line_done;
    logic                       short_line;
  } smooth_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] s;
    bit                         eol;
    bit                         typed;
    int                         n_out;
    logic signed [SAMPLE_W-1:0] val;
    bit                         shrt;
  } dir_row_t;

  typedef enum {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       end_of_line = 1'b0;
  logic                       result_valid;
  logic                       result_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic                       line_done;
  logic                       short_line;

  smooth_t awaited_outputs[$];
  smooth_t step_out[$];
  logic signed [SAMPLE_W-1:0] win_hist [TAPS];
  int      seen;
  longint  tap_weight [TAPS];
  int      mismatches = 0;

  int       burst_left = 0;
  bit       steady = 1'b0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  rx_mode_t rx_mode = RX_ALWAYS;
  logic [15:0] stall_pattern = 16'hffff;
  smooth_t  exp_word;
  smooth_t  got_word;

  dir_row_t dir_rows [22] = '{
    '{ 32767, 1, 1, 1, 0, 1},
    '{-32768, 0, 1, 0, 0, 0},
    '{     0, 0, 1, 0, 0, 0},
    '{     5, 1, 1, 1, 0, 1},
    '{ 32767, 0, 1, 0, 0, 0},
    '{ 32767, 0, 1, 0, 0, 0},
    '{ 32767, 0, 1, 0, 0, 0},
    '{ 32767, 1, 1, 4, 32767, 0},
    '{-32768, 0, 1, 0, 0, 0},
    '{-32768, 0, 1, 0, 0, 0},
    '{-32768, 0, 1, 0, 0, 0},
    '{-32768, 0, 1, 1, -32768, 0},
    '{-32768, 1, 1, 4, -32768, 0},
    '{   100, 0, 0, 0, 0, 0},
    '{  -200, 0, 0, 0, 0, 0},
    '{ 32767, 0, 0, 0, 0, 0},
    '{-32768, 0, 0, 0, 0, 0},
    '{     1, 0, 0, 0, 0, 0},
    '{    -1, 0, 0, 0, 0, 0},
    '{ 21845, 0, 0, 0, 0, 0},
    '{-21846, 0, 0, 0, 0, 0},
    '{  1234, 1, 0, 0, 0, 0}
  };

  binomial_smoothing_fir_mirror #(
    .HALF_WIDTH (HALF_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample      (sample),
    .end_of_line (end_of_line),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .smoothed    (smoothed),
    .line_done   (line_done),
    .short_line  (short_line)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // Shift in one word and compute the outputs it releases into step_out.
  function automatic void smooth_step(input logic signed [SAMPLE_W-1:0] s, input bit eol);
    int      n;
    int      age;
    longint  acc;
    smooth_t r;
    step_out.delete();
    for (int i = TAPS - 1; i > 0; i--) win_hist[i] = win_hist[i - 1];
    win_hist[0] = s;
    if (seen < TAPS) seen++;
    n = seen;
    if (n < HALF_W + 1) begin
      if (eol) begin
        r.smoothed   = '0;
        r.line_done  = 1'b1;
        r.short_line = 1'b1;
        step_out.push_back(r);
        seen = 0;
      end
      return;
    end
    for (int f = 0; f <= (eol ? HALF_W : 0); f++) begin
      acc = 0;
      for (int t = 0; t < TAPS; t++) begin
        age = 2 * HALF_W - f - t;
        if (age < 0) age = -age - 1;
        if (age > n - 1) age = 2 * n - 1 - age;
        acc += tap_weight[t] * longint'(win_hist[age]);
      end
      acc += longint'(1) << (NORM - 1);
      r.smoothed   = SAMPLE_W'(acc >>> NORM);
      r.line_done  = eol && (f == HALF_W);
      r.short_line = 1'b0;
      step_out.push_back(r);
    end
    if (eol) seen = 0;
  endfunction

  task automatic offer_sample(input logic signed [SAMPLE_W-1:0] s, input bit eol);
    if (!steady && burst_left == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    sample_valid <= 1'b1;
    sample       <= s;
    end_of_line  <= eol;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain_outputs();
    sample_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (2 * TAPS) @(posedge clk);
  endtask

  task automatic send_line(input int len);
    logic signed [SAMPLE_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       v = 16'sh7fff;
        1:       v = 16'sh8000;
        2, 3:    v = SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
        default: v = SAMPLE_W'($urandom);
      endcase
      offer_sample(v, i == len - 1);
      smooth_step(v, i == len - 1);
      foreach (step_out[k]) awaited_outputs.push_back(step_out[k]);
    end
  endtask

  // output side: stall modes, one long hold-off on request, scoreboard check
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      got_word = '{smoothed, line_done, short_line};
      if (awaited_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: smoothed=%0d line_done=%0b short_line=%0b",
                   smoothed, line_done, short_line);
        mismatches++;
      end else begin
        exp_word = awaited_outputs.pop_front();
        if (exp_word !== got_word) begin
          if (mismatches < 10)
            $display("mismatch: exp smoothed=%0d line_done=%0b short_line=%0b, got %0d %0b %0b",
                     exp_word.smoothed, exp_word.line_done, exp_word.short_line,
                     smoothed, line_done, short_line);
          mismatches++;
        end
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode       = rx_mode_t'($urandom_range(0, 3));
        mode_left     = $urandom_range(16, 96);
        stall_pattern = 16'($urandom);
      end
      mode_left--;
      case (rx_mode)
        RX_ALWAYS:  result_ready <= 1'b1;
        RX_COIN:    result_ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: begin
          result_ready  <= stall_pattern[0];
          stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
        end
        default:    result_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin
    int  rand_sent;
    int  len;
    bit  pressed;
    bit  paused;
    smooth_t r;
    rand_sent = 0;
    pressed   = 1'b0;
    paused    = 1'b0;
    for (int i = 0; i < TAPS; i++) begin
      win_hist[i]   = '0;
      tap_weight[i] = 0;
    end
    tap_weight[0] = 1;
    for (int i = 1; i < TAPS; i++)
      for (int j = i; j > 0; j--) tap_weight[j] += tap_weight[j - 1];
    seen = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      offer_sample(dir_rows[i].s, dir_rows[i].eol);
      smooth_step(dir_rows[i].s, dir_rows[i].eol);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < dir_rows[i].n_out; k++) begin
          r.smoothed   = dir_rows[i].val;
          r.line_done  = dir_rows[i].eol && (k == dir_rows[i].n_out - 1);
          r.short_line = dir_rows[i].shrt;
          awaited_outputs.push_back(r);
        end
      end else begin
        foreach (step_out[k]) awaited_outputs.push_back(step_out[k]);
      end
    end
    drain_outputs();

    while (rand_sent < RAND_WORDS) begin
      if (!pressed && rand_sent >= 120) begin
        // long receiver hold while the sender streams without gaps
        pressed = 1'b1;
        hold_requests++;
        steady = 1'b1;
        send_line(40);
        steady = 1'b0;
        rand_sent += 40;
      end
      if (!paused && rand_sent >= 240) begin
        paused = 1'b1;
        drain_outputs();
      end
      case ($urandom_range(0, 19))
        0, 1, 2:        len = $urandom_range(1, HALF_W);
        14, 15, 16, 17: len = $urandom_range(13, 30);
        18:             len = HALF_W + 1;
        19:             len = TAPS;
        default:        len = $urandom_range(HALF_W + 1, 12);
      endcase
      send_line(len);
      rand_sent += len;
    end

    drain_outputs();
    if (mismatches == 0 && awaited_outputs.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
